[rtl/shs_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; imported by every module of the block.
package shs_pkg;

   localparam int unsigned BLK_BITS = 512;
   localparam int unsigned WORD_BITS = 32;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   // One message block on its way from the front end to the compression core.
   typedef struct packed {
      logic                is_final;
      logic [BLK_BITS-1:0] data;      // byte 0 in the top bits
   } shs_blk_type;

   // Front end to queue: push strobe and block.
   typedef struct packed {
      logic        push;
      shs_blk_type blk;
   } shs_push_type;

   // Queue to compression core: head entry and its presence.
   typedef struct packed {
      logic        avail;
      shs_blk_type blk;
   } shs_head_type;

   function automatic logic [31:0] shs_iv(input logic [2:0] idx);
      logic [31:0] r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h6a09e667;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] shs_k(input logic [5:0] idx);
      logic [31:0] r;
      case (idx)
         6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
         default: r = 32'h428a2f98;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
      logic [63:0] t;
      t = {v, v} >> s;
      return t[31:0];
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] v);
      return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] v);
      return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] v);
      return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] v);
      return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

[rtl/shs_front.sv]
// Front end: takes message bytes, appends padding and length, builds 512-bit blocks.
// Depends on shs_pkg; feeds shs_queue.
module shs_front
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         q_full,
   output shs_push_type push_out
);

   localparam logic [1:0] ST_MSG    = 2'd0;
   localparam logic [1:0] ST_PAD80  = 2'd1;
   localparam logic [1:0] ST_PADZ   = 2'd2;
   localparam logic [1:0] ST_PADLEN = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [5:0]          pos_ff, pos_in;
   logic [63:0]         len_ff, len_in;
   logic [BLK_BITS-1:0] blk_ff, blk_in;
   logic [63:0]         len_sh;
   logic [7:0]          byte_sel;
   logic                stall, go, blk_done;

   // A byte that closes a block waits until the queue has room.
   assign stall      = (pos_ff == 6'd63) && q_full;
   assign req_tready = (state_ff == ST_MSG) && !stall;
   assign go         = ((state_ff == ST_MSG) ? req_tvalid : 1'b1) && !stall;
   assign blk_done   = go && (pos_ff == 6'd63);
   assign len_sh     = len_ff << {pos_ff[2:0], 3'b000};

   always_comb begin
      case (state_ff)
         ST_MSG:    byte_sel = req_tdata;
         ST_PAD80:  byte_sel = PAD_BYTE;
         ST_PADZ:   byte_sel = 8'h00;
         ST_PADLEN: byte_sel = len_sh[63:56];
         default:   byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      blk_in   = blk_ff;
      if (go) begin
         blk_in = {blk_ff[BLK_BITS-9:0], byte_sel};
         pos_in = pos_ff + 6'd1;
         case (state_ff)
            ST_MSG: begin
               len_in = len_ff + 64'd8;
               if (req_tlast) state_in = ST_PAD80;
            end
            ST_PAD80, ST_PADZ: begin
               // length bytes fill positions 56 to 63
               if (pos_ff == LEN_POS - 6'd1) state_in = ST_PADLEN;
               else state_in = ST_PADZ;
            end
            ST_PADLEN: begin
               if (pos_ff == 6'd63) begin
                  state_in = ST_MSG;
                  len_in   = 64'd0;
               end
            end
            default: state_in = ST_MSG;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MSG;
         pos_ff   <= 6'd0;
         len_ff   <= 64'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign push_out.push         = blk_done;
   assign push_out.blk.is_final = (state_ff == ST_PADLEN);
   assign push_out.blk.data     = {blk_ff[BLK_BITS-9:0], byte_sel};

endmodule

[rtl/shs_queue.sv]
// Two-entry block queue between the front end and the compression core.
// Depends on shs_pkg.
module shs_queue
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  shs_push_type push_in,
   output logic         q_full,
   input  logic         pop,
   output shs_head_type head
);

   shs_blk_type ent_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;

   assign q_full     = (cnt_ff == 2'd2);
   assign head.avail = (cnt_ff != 2'd0);
   assign head.blk   = ent_ff[rd_ptr_ff];

   always_comb begin
      case ({push_in.push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_in.push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) ent_ff[wr_ptr_ff] <= push_in.blk;
   end

endmodule

[rtl/shs_back.sv]
// Compression core: one SHA-256 round per cycle, chaining update, digest register.
// Depends on shs_pkg; drains shs_queue.
module shs_back
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  shs_head_type head,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata
);

   localparam logic [1:0] B_IDLE   = 2'd0;
   localparam logic [1:0] B_ROUND  = 2'd1;
   localparam logic [1:0] B_FINISH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [5:0]           rnd_ff;
   logic                 fin_ff;
   logic [WORD_BITS-1:0] h_ff [8];
   logic [WORD_BITS-1:0] v_ff [8];
   logic [WORD_BITS-1:0] w_ff [16];
   logic [WORD_BITS-1:0] sum [8];
   logic [255:0]         dig_ff;
   logic                 vld_ff;
   logic [WORD_BITS-1:0] t1, t2, ch, maj, w_new;
   logic                 out_busy, do_fin;

   assign out_busy = vld_ff && !rsp_tready;
   assign pop      = (state_ff == B_IDLE) && head.avail;
   assign do_fin   = (state_ff == B_FINISH) && !(fin_ff && out_busy);

   assign ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1    = v_ff[7] + big_sig1(v_ff[4]) + ch + shs_k(rnd_ff) + w_ff[0];
   assign t2    = big_sig0(v_ff[0]) + maj;
   assign w_new = small_sig1(w_ff[14]) + w_ff[9] + small_sig0(w_ff[1]) + w_ff[0];

   always_comb begin
      for (int j = 0; j < 8; j++) sum[j] = h_ff[j] + v_ff[j];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (head.avail) state_in = B_ROUND;
         B_ROUND:  if (rnd_ff == 6'd63) state_in = B_FINISH;
         B_FINISH: if (do_fin) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         vld_ff   <= 1'b0;
         for (int j = 0; j < 8; j++) h_ff[j] <= shs_iv(3'(j));
      end else begin
         state_ff <= state_in;
         if (do_fin && fin_ff) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
         if (do_fin) begin
            for (int j = 0; j < 8; j++) h_ff[j] <= fin_ff ? shs_iv(3'(j)) : sum[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rnd_ff <= 6'd0;
         fin_ff <= head.blk.is_final;
         for (int j = 0; j < 16; j++) w_ff[j] <= head.blk.data[BLK_BITS-1-32*j -: 32];
         for (int j = 0; j < 8; j++) v_ff[j] <= h_ff[j];
      end else if (state_ff == B_ROUND) begin
         rnd_ff <= rnd_ff + 6'd1;
         for (int j = 0; j < 15; j++) w_ff[j] <= w_ff[j+1];
         w_ff[15] <= w_new;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
      if (do_fin && fin_ff) begin
         dig_ff <= {sum[6], sum[7], sum[4], sum[5], sum[2], sum[3], sum[0], sum[1]};
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dig_ff;

endmodule

[rtl/sha256_stream_hasher_top.sv]
// Top level of the SHA-256 stream hasher: front end, block queue, compression core.
// Depends on shs_pkg, shs_front, shs_queue and shs_back.
//
// Usage:
//  - req channel: one message byte per transfer (req_tdata), req_tlast high on the
//    final byte of a message. Empty messages cannot be sent.
//  - rsp channel: one transfer per message carrying the 256-bit digest as four
//    big-endian 64-bit words, word 0 in the lowest bits.
//  - Message bytes are taken one per cycle. Each full 512-bit block is handed
//    to a two-entry queue; the core loads it, runs the SHA-256 rounds and does
//    the chaining add, and only then takes the next block. The front end holds
//    req_tready low while it inserts padding and when a block would close while
//    the queue is full.
//  - After the final byte the front end inserts padding and the 64-bit length,
//    one byte per cycle unless a block would close into a full queue (9 to 72
//    bytes), so one or two more blocks are queued. The digest appears in the
//    cycle after the last block's chaining add.
//  - While a digest waits on rsp_tready, the core keeps compressing blocks of the
//    next message and only holds at the next final chaining add.
//  - Reset (synchronous) empties the queue, clears position and length and loads
//    the initial hash values; no clearing pass is needed.
module sha256_stream_hasher_top
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // [63:0] digest_word_0, [127:64] digest_word_1,
                                     // [191:128] digest_word_2, [255:192] digest_word_3
);

   shs_push_type q_push;
   shs_head_type q_head;
   logic         q_full;
   logic         q_pop;

   shs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push_out   (q_push)
   );

   shs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (q_push),
      .q_full  (q_full),
      .pop     (q_pop),
      .head    (q_head)
   );

   shs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The front end never pushes a block into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_full)
      else $error("block pushed into full queue");

   // The core only pops an entry that is present.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.avail)
      else $error("block popped from empty queue");

   // A byte is taken only when no block is waiting to be closed into a full queue.
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      (req_tready && q_full) |-> !q_push.push)
      else $error("input ready while a block cannot be queued");

endmodule

[tb/sha256_digest_checker.sv]
// Digest scoreboard for the SHA-256 stream hasher: rebuilds each message from req
// transfers, predicts its digest and compares every rsp transfer field by field.
// No package dependencies; instantiated by tb_top next to the block.
module sha256_digest_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,   // [63:0] word 0 .. [255:192] word 3
   output int           mismatch_count,
   output int           digests_pending
);

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [0:7][31:0] IV_WORDS = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LENGTH_SLOT = 6'd56;

   logic [31:0]  hash_words [8];
   logic [7:0]   block_bytes [64];
   logic [5:0]   fill_pos;
   logic [63:0]  msg_bits;
   logic [255:0] digest_fifo [$];
   int           errors = 0;
   int           outstanding = 0;
   int           digests_seen = 0;

   assign mismatch_count  = errors;
   assign digests_pending = outstanding;

   task automatic report_error(input string msg);
      $display("digest check: %s", msg);
      errors++;
   endtask

   function automatic logic [31:0] ror(input logic [31:0] x, input int s);
      return (x >> s) | (x << (32 - s));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_words[i] = IV_WORDS[i];
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      fill_pos = 6'd0;
      msg_bits = 64'd0;
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
      e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
      hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
   endtask

   task automatic absorb_byte(input logic [7:0] value);
      block_bytes[fill_pos] = value;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_block();
   endtask

   // Pad with the marker byte, zeros up to the length slot, then the bit count
   // (already wrapped to 64 bits) most significant byte first.
   task automatic finish_message(output logic [255:0] digest);
      logic [63:0] bit_len;
      bit_len = msg_bits;
      absorb_byte(PAD_MARK);
      while (fill_pos != LENGTH_SLOT) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
      digest = {hash_words[6], hash_words[7], hash_words[4], hash_words[5],
                hash_words[2], hash_words[3], hash_words[0], hash_words[1]};
      restart_message();
   endtask

   always @(posedge clock) begin : monitor
      logic [255:0] want;
      if (reset) begin
         restart_message();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_fifo.size() == 0) begin
               report_error($sformatf("unexpected digest %h", rsp_tdata));
            end else begin
               want = digest_fifo.pop_front();
               outstanding--;
               for (int k = 0; k < 4; k++)
                  if (rsp_tdata[64*k +: 64] !== want[64*k +: 64])
                     report_error($sformatf("digest %0d word %0d: got %h, expected %h",
                                            digests_seen, k, rsp_tdata[64*k +: 64],
                                            want[64*k +: 64]));
            end
            digests_seen++;
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
            msg_bits += 64'd8;
            if (req_tlast) begin
               finish_message(want);
               digest_fifo.push_back(want);
               outstanding++;
            end
         end
      end
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the SHA-256 stream hasher: clock, reset, byte stimulus and
// receiver back-pressure. Depends on sha256_stream_hasher_top and sha256_digest_checker.
module tb_top;

   // Generous cycle budget for the whole run.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Long receiver hold-off; several digests pile up and the queue backs up to req.
   localparam int          HOLD_CYCLES = 3000;
   // Drain time after the last digest.
   localparam int          DRAIN_CYCLES = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // [7:0] data_byte
   logic         req_tlast = 1'b0;    // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;           // [63:0] digest_word_0 .. [255:192] digest_word_3

   int           fail_count;
   int           pending_count;

   // Idle mix, changed per phase by the stimulus process.
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;

   // Hold-off request: set by stimulus, taken and counted down by the receiver.
   bit           hold_wanted = 1'b0;
   int           hold_left = 0;

   int           items_sent = 0;
   int           msgs_sent = 0;
   int unsigned  cycle_count = 0;

   sha256_stream_hasher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sha256_digest_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (fail_count),
      .digests_pending (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random stalls per the current phase, or a long hold-off on request.
   always @(posedge clock) begin
      if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // One byte transfer. Optional idle cycles first; valid stays high between
   // back-to-back bytes so it is never dropped and raised in the same step.
   // Returns right after the edge at which the transfer happened.
   task automatic offer_byte(input logic [7:0] value, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         offer_byte(8'($urandom_range(255)), i == len - 1);
      msgs_sent++;
   endtask

   // Random messages under one idle mix. Lengths: mostly short, the rest around
   // the one/two padding-block boundary (55/56, 63/64) and its two-block twin
   // (119/120, 127/128).
   task automatic run_phase(input int sender_pct, input int receiver_pct, input int quota);
      int start_items;
      int start_msgs;
      int pick;
      int len;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      start_items = items_sent;
      start_msgs  = msgs_sent;
      while (items_sent - start_items < quota || msgs_sent - start_msgs < 4) begin
         pick = $urandom_range(99);
         if (pick < 60)
            len = $urandom_range(6, 1);
         else if (pick < 90)
            len = $urandom_range(68, 52);
         else
            len = $urandom_range(132, 116);
         send_message(len);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-byte messages at the data extremes, the classic "abc",
      // an alternating-bit message, walking ones, and the pad value as data.
      offer_byte(8'h00, 1'b1);
      offer_byte(8'hff, 1'b1);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h63, 1'b1);
      for (int i = 0; i < 8; i++)
         offer_byte(i[0] ? 8'haa : 8'h55, i == 7);
      for (int i = 0; i < 8; i++)
         offer_byte(8'h01 << i, i == 7);
      offer_byte(8'h80, 1'b1);

      // Random part. The hold-off starts with the no-idle phase so the sender
      // keeps pushing while digests back up and req_tready has to drop.
      hold_wanted = 1'b1;
      run_phase(0, 0, 140);
      run_phase(48, 0, 140);
      run_phase(0, 48, 140);
      run_phase(15, 15, 140);

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Let the checker see the last transfer, wait for every digest, then
      // leave room for anything stray to show up.
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
